// ===== hdl/ordered_list_with_index_delete_top_assert.svh =====
// assertion macros for the ordered list block
`ifndef ORDERED_LIST_WITH_INDEX_DELETE_TOP_ASSERT_SVH
`define ORDERED_LIST_WITH_INDEX_DELETE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define OLID_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordered list check failed");

// next-cycle implication, sampled on clock, off during reset
`define OLID_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordered list check failed");

`endif

// ===== hdl/olid_pkg.sv =====
// shared types and codes for the ordered list block
`timescale 1ns / 1ps
package olid_pkg;

   localparam logic [2:0] CMD_APPEND      = 3'd0;
   localparam logic [2:0] CMD_REMOVE_HEAD = 3'd1;
   localparam logic [2:0] CMD_REMOVE_AT   = 3'd2;
   localparam logic [2:0] CMD_REMOVE_TAIL = 3'd3;
   localparam logic [2:0] CMD_FIND        = 3'd4;
   localparam logic [2:0] CMD_CLEAR       = 3'd5;

   localparam logic [1:0] STS_DONE    = 2'd0;
   localparam logic [1:0] STS_FULL    = 2'd1;
   localparam logic [1:0] STS_REFUSED = 2'd2;

   typedef enum logic [0:0] {
      S_IDLE,
      S_SCAN
   } state_type;

   typedef struct packed {
      logic exec;
      logic scan_start;
      logic scan_step;
      logic scan_finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_stat_type;

endpackage

// ===== hdl/olid_ctrl.sv =====
// controller: handshake, find scan sequencing and result valid
`timescale 1ns / 1ps
module olid_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  cmd_is_find,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output olid_pkg::ctrl_cmd_type ctl,
   input  olid_pkg::dp_stat_type  stat
);
   import olid_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      ctl             = '0;
      req_ready       = 1'b0;
      accept          = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // result register must be empty or draining this cycle
            req_ready = !rsp_valid_ff || rsp_ready;
            accept    = req_valid && req_ready;
            if (accept) begin
               if (cmd_is_find) begin
                  ctl.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  ctl.exec = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               ctl.scan_finish = 1'b1;
               state_in        = S_IDLE;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ctl.exec || ctl.scan_finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/olid_dp.sv =====
// datapath: row of entry cells, count, search scan and result register
`timescale 1ns / 1ps
module olid_dp #(
   parameter int LIST_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  olid_pkg::ctrl_cmd_type ctl,
   output olid_pkg::dp_stat_type  stat,
   input  logic [2:0]             req_command,
   input  logic [7:0]             req_value,
   input  logic [3:0]             req_position,
   output logic [1:0]             rsp_status,
   output logic                   rsp_found,
   output logic [3:0]             rsp_found_position,
   output logic [4:0]             rsp_entry_count
);
   import olid_pkg::*;

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int EW = CW + 4;

   logic [7:0]    cells_ff [LIST_DEPTH];
   logic [7:0]    cells_in [LIST_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [7:0]    key_ff, key_in;
   logic [1:0]    status_ff, status_in;
   logic          found_ff, found_in;
   logic [3:0]    fpos_ff, fpos_in;
   logic [4:0]    ecount_ff, ecount_in;

   logic          do_append, do_shift;
   logic [EW-1:0] rm_pos;
   logic [EW-1:0] pos_ext, count_ext, scan_ext, count_in_ext;
   logic [1:0]    exec_status;
   logic          in_range, hit;

   assign pos_ext      = EW'(req_position);
   assign count_ext    = EW'(count_ff);
   assign scan_ext     = EW'(scan_ff);
   assign count_in_ext = EW'(count_in);

   // command decode for everything but find
   always_comb begin
      do_append   = 1'b0;
      do_shift    = 1'b0;
      rm_pos      = '0;
      count_in    = count_ff;
      exec_status = STS_DONE;
      unique case (req_command)
         CMD_APPEND: begin
            if (count_ff < CW'(LIST_DEPTH)) begin
               do_append = 1'b1;
               count_in  = CW'(count_ff + 1'b1);
            end else begin
               exec_status = STS_FULL;
            end
         end
         CMD_REMOVE_HEAD: begin
            if (count_ff != '0) begin
               do_shift = 1'b1;
               count_in = CW'(count_ff - 1'b1);
            end else begin
               exec_status = STS_REFUSED;
            end
         end
         CMD_REMOVE_AT: begin
            rm_pos = pos_ext;
            if (pos_ext < count_ext) begin
               do_shift = 1'b1;
               count_in = CW'(count_ff - 1'b1);
            end else begin
               exec_status = STS_REFUSED;
            end
         end
         CMD_REMOVE_TAIL: begin
            if (count_ff != '0) begin
               count_in = CW'(count_ff - 1'b1);
            end else begin
               exec_status = STS_REFUSED;
            end
         end
         CMD_FIND: begin
            exec_status = STS_DONE;
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
            exec_status = STS_REFUSED;
         end
      endcase
   end

   // cells load the appended byte or (all but the last) the right neighbor
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      if (i < LIST_DEPTH - 1) begin : g_inner
         always_comb begin
            cells_in[i] = cells_ff[i];
            if (do_append && (count_ff == CW'(i))) begin
               cells_in[i] = req_value;
            end else if (do_shift && (EW'(i) >= rm_pos)) begin
               cells_in[i] = cells_ff[i+1];
            end
         end
      end else begin : g_last
         always_comb begin
            cells_in[i] = cells_ff[i];
            if (do_append && (count_ff == CW'(i))) begin
               cells_in[i] = req_value;
            end
         end
      end
   end

   // search walks one cell per cycle
   assign in_range       = scan_ff < count_ff;
   assign hit            = in_range && (cells_ff[scan_ff[IW-1:0]] == key_ff);
   assign stat.scan_done = hit || !in_range;

   always_comb begin
      key_in    = key_ff;
      scan_in   = scan_ff;
      status_in = status_ff;
      found_in  = found_ff;
      fpos_in   = fpos_ff;
      ecount_in = ecount_ff;
      if (ctl.scan_start) begin
         key_in  = req_value;
         scan_in = '0;
      end else if (ctl.scan_step) begin
         scan_in = CW'(scan_ff + 1'b1);
      end
      if (ctl.exec) begin
         status_in = exec_status;
         found_in  = 1'b0;
         fpos_in   = '0;
         ecount_in = count_in_ext[4:0];
      end else if (ctl.scan_finish) begin
         status_in = STS_DONE;
         found_in  = hit;
         fpos_in   = hit ? scan_ext[3:0] : 4'd0;
         ecount_in = count_ext[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         cells_ff <= cells_in;
      end
      key_ff    <= key_in;
      scan_ff   <= scan_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      fpos_ff   <= fpos_in;
      ecount_ff <= ecount_in;
   end

   assign rsp_status         = status_ff;
   assign rsp_found          = found_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_entry_count    = ecount_ff;

endmodule

// ===== hdl/ordered_list_with_index_delete_top.sv =====
// append, removals, clear and bad codes give their result in the cycle after accept
// find: scans one entry per cycle from the head, registers its result at the first match
// or at the end of the list when nothing matches, and holds off new items while it scans
// throughput: one non-find item per cycle while the result register drains
// reset: clears the entry count and the result valid; entry contents are not cleared
`timescale 1ns / 1ps
module ordered_list_with_index_delete_top #(
   parameter int LIST_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [7:0] req_value,
   input  logic [3:0] req_position,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic       rsp_found,
   output logic [3:0] rsp_found_position,
   output logic [4:0] rsp_entry_count
);
   import olid_pkg::*;

   ctrl_cmd_type ctl;
   dp_stat_type  stat;

   olid_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .cmd_is_find (req_command == CMD_FIND),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .ctl         (ctl),
      .stat        (stat)
   );

   olid_dp #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .stat               (stat),
      .req_command        (req_command),
      .req_value          (req_value),
      .req_position       (req_position),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count)
   );

`include "ordered_list_with_index_delete_top_assert.svh"

   // a non-find item always has its result waiting on the next cycle
   `OLID_ASSERT_NEXT(a_exec_result, req_valid && req_ready && req_command != CMD_FIND, rsp_valid)
   // no new item is taken while the search is still walking
   `OLID_ASSERT_NOW(a_scan_blocks, ctl.scan_step || ctl.scan_finish, !req_ready)
   // a match is only ever reported with a done status
   `OLID_ASSERT_NOW(a_found_done, rsp_valid && rsp_found, rsp_status == STS_DONE)

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the ordered list block: directed table, then random commands
`timescale 1ns / 1ps
module testbench;
   import olid_pkg::*;

   localparam int LIST_DEPTH    = 16;
   localparam int NUM_DIRECTED  = 29;
   localparam int ITEMS_PER_MODE = 275;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 24;
   localparam int CYCLE_LIMIT   = 500000;

   // codes outside the defined command set
   localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [3:0] found_position;
      logic [4:0] entry_count;
   } list_rsp_type;

   typedef struct packed {
      logic [2:0]   command;
      logic [7:0]   value;
      logic [3:0]   position;
      logic         typed_in;
      list_rsp_type want;
   } dir_row_type;

   localparam list_rsp_type NO_TYPED = '0;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_command = CMD_APPEND;
   logic [7:0] req_value = 8'h00;
   logic [3:0] req_position = 4'h0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic       rsp_found;
   logic [3:0] rsp_found_position;
   logic [4:0] rsp_entry_count;

   // shadow copy of the list, updated as each item is accepted
   logic [7:0] shadow_entries [LIST_DEPTH];
   logic [4:0] shadow_count = '0;

   list_rsp_type expected_rsp [$];
   list_rsp_type rsp_want;
   int         mismatch_count = 0;
   int         results_checked = 0;
   int         cycle_count = 0;
   int         send_gap_pct = 0;
   int         recv_stall_pct = 0;
   int         hold_left = 0;
   logic       hold_request = 1'b0;

   dir_row_type directed_rows [NUM_DIRECTED] = '{
      '{CMD_REMOVE_HEAD, 8'h00, 4'h0, 1'b1, '{STS_REFUSED, 1'b0, 4'h0, 5'd0}},
      '{CMD_REMOVE_TAIL, 8'h00, 4'h0, 1'b1, '{STS_REFUSED, 1'b0, 4'h0, 5'd0}},
      '{CMD_REMOVE_AT,   8'h00, 4'h0, 1'b1, '{STS_REFUSED, 1'b0, 4'h0, 5'd0}},
      '{CMD_FIND,        8'h00, 4'h0, 1'b1, '{STS_DONE,    1'b0, 4'h0, 5'd0}},
      '{CMD_UNUSED_6,    8'h00, 4'h0, 1'b1, '{STS_REFUSED, 1'b0, 4'h0, 5'd0}},
      '{CMD_UNUSED_7,    8'hFF, 4'hF, 1'b1, '{STS_REFUSED, 1'b0, 4'h0, 5'd0}},
      '{CMD_APPEND,      8'h00, 4'h0, 1'b1, '{STS_DONE,    1'b0, 4'h0, 5'd1}},
      '{CMD_APPEND,      8'hFF, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'h01, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'h02, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'h04, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'h08, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'h10, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'h20, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'h40, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'h80, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'hFE, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'hFD, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'hFB, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'hF7, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'hEF, 4'h0, 1'b0, NO_TYPED},
      '{CMD_APPEND,      8'hDF, 4'h0, 1'b1, '{STS_DONE,    1'b0, 4'h0, 5'd16}},
      '{CMD_APPEND,      8'h55, 4'h0, 1'b1, '{STS_FULL,    1'b0, 4'h0, 5'd16}},
      '{CMD_REMOVE_AT,   8'h00, 4'hF, 1'b1, '{STS_DONE,    1'b0, 4'h0, 5'd15}},
      '{CMD_REMOVE_AT,   8'h00, 4'hF, 1'b1, '{STS_REFUSED, 1'b0, 4'h0, 5'd15}},
      '{CMD_FIND,        8'hEF, 4'h0, 1'b0, NO_TYPED},
      '{CMD_REMOVE_HEAD, 8'h00, 4'h0, 1'b0, NO_TYPED},
      '{CMD_REMOVE_TAIL, 8'h00, 4'h0, 1'b0, NO_TYPED},
      '{CMD_CLEAR,       8'h00, 4'h0, 1'b1, '{STS_DONE,    1'b0, 4'h0, 5'd0}}
   };

   ordered_list_with_index_delete_top #(
      .LIST_DEPTH(LIST_DEPTH)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_found_position(rsp_found_position),
      .rsp_entry_count   (rsp_entry_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("ordered_list_with_index_delete_top test failed");
      $finish;
   end

   // applies one command to the shadow list and returns the result it should give
   function automatic list_rsp_type apply_list_command(input logic [2:0] cmd,
                                                       input logic [7:0] val,
                                                       input logic [3:0] pos);
      list_rsp_type r;
      int        gap;
      int        i;
      r = '0;
      r.status = STS_DONE;
      case (cmd) inside
         CMD_APPEND: begin
            if (shadow_count >= LIST_DEPTH) begin
               r.status = STS_FULL;
            end else begin
               shadow_entries[shadow_count[3:0]] = val;
               shadow_count = shadow_count + 1'b1;
            end
         end
         CMD_REMOVE_HEAD, CMD_REMOVE_AT: begin
            gap = (cmd == CMD_REMOVE_HEAD) ? 0 : int'(pos);
            if (gap >= shadow_count) begin
               r.status = STS_REFUSED;
            end else begin
               // later entries close up over the removed one
               for (i = gap; i + 1 < shadow_count; i++) begin
                  shadow_entries[i] = shadow_entries[i + 1];
               end
               shadow_count = shadow_count - 1'b1;
            end
         end
         CMD_REMOVE_TAIL: begin
            if (shadow_count == 0) begin
               r.status = STS_REFUSED;
            end else begin
               shadow_count = shadow_count - 1'b1;
            end
         end
         CMD_FIND: begin
            for (i = 0; i < shadow_count && !r.found; i++) begin
               if (shadow_entries[i] == val) begin
                  r.found = 1'b1;
                  r.found_position = i[3:0];
               end
            end
         end
         CMD_CLEAR: begin
            shadow_count = '0;
         end
         default: begin
            r.status = STS_REFUSED;
         end
      endcase
      r.entry_count = shadow_count;
      return r;
   endfunction

   // called just after the clock rises; returns at the edge where the item is taken
   task automatic send_item(input logic [2:0] cmd, input logic [7:0] val,
                            input logic [3:0] pos, input logic typed_in,
                            input list_rsp_type typed_want);
      list_rsp_type want;
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_value    <= val;
      req_position <= pos;
      do @(posedge clock); while (!(req_valid && req_ready));
      want = apply_list_command(cmd, val, pos);
      if (typed_in) begin
         want = typed_want;
      end
      expected_rsp.push_back(want);
   endtask

   // mostly commands that make sense for the current list, with some noise
   task automatic pick_list_command(input int grow_pct, output logic [2:0] cmd,
                                    output logic [7:0] val, output logic [3:0] pos);
      int roll;
      roll = $urandom_range(99);
      val  = 8'($urandom_range(255));
      pos  = 4'($urandom_range(15));
      if (roll < grow_pct) begin
         cmd = CMD_APPEND;
      end else if (roll < grow_pct + 25) begin
         cmd = CMD_FIND;
         if (shadow_count != 0 && $urandom_range(99) < 70) begin
            val = shadow_entries[4'($urandom_range(shadow_count - 1))];
         end
      end else if (roll < 95) begin
         case ($urandom_range(2))
            0: cmd = CMD_REMOVE_HEAD;
            1: cmd = CMD_REMOVE_TAIL;
            default: begin
               cmd = CMD_REMOVE_AT;
               if (shadow_count != 0 && $urandom_range(99) < 80) begin
                  pos = 4'($urandom_range(shadow_count - 1));
               end
            end
         endcase
      end else if (roll < 96) begin
         cmd = CMD_CLEAR;
      end else begin
         cmd = 3'($urandom_range(CMD_UNUSED_7, CMD_UNUSED_6));
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("mismatch at result %0d: %s is %0d, expected %0d",
               results_checked, what, got, want);
   endtask

   // result side: check what was taken at this edge, then choose the next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("result with nothing pending", 1, 0);
         end else begin
            rsp_want = expected_rsp.pop_front();
            if (rsp_status !== rsp_want.status) begin
               report_mismatch("status", rsp_status, rsp_want.status);
            end
            if (rsp_found !== rsp_want.found) begin
               report_mismatch("found", rsp_found, rsp_want.found);
            end
            if (rsp_found_position !== rsp_want.found_position) begin
               report_mismatch("found_position", rsp_found_position,
                               rsp_want.found_position);
            end
            if (rsp_entry_count !== rsp_want.entry_count) begin
               report_mismatch("entry_count", rsp_entry_count, rsp_want.entry_count);
            end
         end
         results_checked++;
      end
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int         row;
      int         mode;
      int         n;
      logic [2:0] cmd;
      logic [7:0] val;
      logic [3:0] pos;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < NUM_DIRECTED; row++) begin
         send_item(directed_rows[row].command, directed_rows[row].value,
                   directed_rows[row].position, directed_rows[row].typed_in,
                   directed_rows[row].want);
      end

      // idle modes: none, sender gaps, receiver stalls, both
      for (mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
            default: begin send_gap_pct = 21; recv_stall_pct = 21; end
         endcase
         // long receiver hold-off so the block backs up into its input
         if (mode == 0) begin
            hold_request = 1'b1;
         end
         for (n = 0; n < ITEMS_PER_MODE; n++) begin
            pick_list_command(((n / 40) % 2 == 0) ? 65 : 15, cmd, val, pos);
            send_item(cmd, val, pos, 1'b0, NO_TYPED);
         end
      end
      req_valid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         report_mismatch("results never delivered", 0, expected_rsp.size());
      end

      if (mismatch_count == 0) begin
         $display("ordered_list_with_index_delete_top test passed");
      end else begin
         $display("ordered_list_with_index_delete_top test failed");
      end
      $finish;
   end

endmodule
